// File: rtl/bitplane_rectangle_fill_macros.svh
// Assertion helpers for the checker file of the fill engine.
`ifndef BITPLANE_RECTANGLE_FILL_MACROS_SVH
`define BITPLANE_RECTANGLE_FILL_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BRF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("brf checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define BRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("brf checker: next-cycle property failed");

`endif

// File: rtl/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

    // Field and port widths fixed by the item format.
    localparam int COORD_W     = 13;
    localparam int COLOUR_W    = 24;
    localparam int XC_W        = 9;
    localparam int YC_W        = 8;
    localparam int WORD_BITS   = 32;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Register indexes, decoded from the word address.
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // Operation codes.
    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Colour byte masks.
    localparam logic [COLOUR_W-1:0] RED_MASK   = 24'hFF0000;
    localparam logic [COLOUR_W-1:0] GREEN_MASK = 24'h00FF00;
    localparam logic [COLOUR_W-1:0] BLUE_MASK  = 24'h0000FF;

    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_word WORD_ONES = 32'hFFFF_FFFF;

    // One memory entry holds the same word of all three planes.
    typedef struct packed {
        t_word red;
        t_word green;
        t_word blue;
    } t_planes;

endpackage

// File: rtl/bitplane_rectangle_fill.sv
`timescale 1ns / 1ps

// Rectangle fill and pixel read engine for a frame buffer of three one-bit planes
// (red, green, blue), 32 pixels per word with the leftmost pixel in the MSB. The
// three planes share one memory entry per word, and every item goes through one
// read-modify-write port, one word per cycle. After reset the block clears all
// WORDS_PER_ROW * MAX_ROWS memory entries, one per cycle, with busy high. An item
// is taken when start is high and busy is low. A fill passes through S_SETUP, one
// S_FILL step per word of its clamped rectangle, and S_FLUSH before its result;
// a pixel read passes through S_SETUP and S_READ, or S_SETUP only off screen.
// The result is shown on o_done for one cycle only and cannot be stalled, so the
// receiver must take it in that cycle. busy is low in the result cycle, so a new
// item can be accepted there. Configuration writes must only be made while idle.
module bitplane_rectangle_fill import brf_pkg::*; #(
    parameter int WORDS_PER_ROW = 10,
    parameter int MAX_ROWS      = 240
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready,
    // Item channel.
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_op,
    input  logic signed [COORD_W-1:0]  i_corner_a_x,
    input  logic signed [COORD_W-1:0]  i_corner_a_y,
    input  logic signed [COORD_W-1:0]  i_corner_b_x,
    input  logic signed [COORD_W-1:0]  i_corner_b_y,
    input  logic [COLOUR_W-1:0]        i_colour,
    // Result channel.
    output logic                       o_done,
    output logic                       o_in_range,
    output logic                       o_red_bit,
    output logic                       o_green_bit,
    output logic                       o_blue_bit
);

    localparam int DEPTH = WORDS_PER_ROW * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
    localparam int MAXW  = WORDS_PER_ROW * WORD_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    logic [2:0]                r_state, n_state;
    logic [XC_W-1:0]           r_sw;
    logic [YC_W-1:0]           r_sh;
    logic                      r_op;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic                      r_cr, r_cg, r_cb;
    logic [AW-1:0]             r_clr;
    logic [AW-1:0]             r_base;
    logic [YC_W-1:0]           r_row, r_y1;
    logic [WW-1:0]             r_word, r_w0, r_w1;
    t_word                     r_lmask, r_rmask;
    logic                      r_wr_vld;
    logic [AW-1:0]             r_wr_addr;
    t_word                     r_wr_mask;
    logic                      r_done, r_in_range, r_red, r_green, r_blue;

    logic [XC_W-1:0]           act_w;
    logic [YC_W-1:0]           act_h;
    logic signed [COORD_W-1:0] act_w_s, act_h_s;
    logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic [XC_W-1:0]           x0c, x1c;
    logic [YC_W-1:0]           y0c, y1c;
    logic                      pix_on;
    logic [AW-1:0]             pix_addr;
    logic [AW-1:0]             fill_addr;
    t_word                     cur_mask;
    logic                      ram_wr_en, ram_rd_en;
    logic [AW-1:0]             ram_wr_addr, ram_rd_addr;
    t_planes                   ram_wr_data, ram_rd_data;
    logic [4:0]                bit_sel;
    logic                      cfg_wr;

    // Clamp a signed coordinate into 0 .. size - 1.
    function automatic logic [XC_W-1:0] clamp_x(input logic signed [COORD_W-1:0] v,
                                                 input logic [XC_W-1:0] size);
        logic signed [COORD_W-1:0] s;
        s = $signed({{(COORD_W-XC_W){1'b0}}, size});
        if (v < 0) begin
            return '0;
        end else if (v >= s) begin
            return size - 1'b1;
        end
        return v[XC_W-1:0];
    endfunction

    function automatic logic [YC_W-1:0] clamp_y(input logic signed [COORD_W-1:0] v,
                                                 input logic [YC_W-1:0] size);
        logic signed [COORD_W-1:0] s;
        s = $signed({{(COORD_W-YC_W){1'b0}}, size});
        if (v < 0) begin
            return '0;
        end else if (v >= s) begin
            return size - 1'b1;
        end
        return v[YC_W-1:0];
    endfunction

    // Active screen size: zero counts as one, and the storage bounds limit it.
    always_comb begin
        if (r_sw == '0) begin
            act_w = XC_W'(1);
        end else if (int'(r_sw) > MAXW) begin
            act_w = XC_W'(MAXW);
        end else begin
            act_w = r_sw;
        end
        if (r_sh == '0) begin
            act_h = YC_W'(1);
        end else if (int'(r_sh) > MAX_ROWS) begin
            act_h = YC_W'(MAX_ROWS);
        end else begin
            act_h = r_sh;
        end
        act_w_s = $signed({{(COORD_W-XC_W){1'b0}}, act_w});
        act_h_s = $signed({{(COORD_W-YC_W){1'b0}}, act_h});
    end

    // Order and clamp the corners of a fill.
    always_comb begin
        x_lo = (r_ax < r_bx) ? r_ax : r_bx;
        x_hi = (r_ax < r_bx) ? r_bx : r_ax;
        y_lo = (r_ay < r_by) ? r_ay : r_by;
        y_hi = (r_ay < r_by) ? r_by : r_ay;
        x0c  = clamp_x(x_lo, act_w);
        x1c  = clamp_x(x_hi, act_w);
        y0c  = clamp_y(y_lo, act_h);
        y1c  = clamp_y(y_hi, act_h);
    end

    // Range test and word address of a pixel read.
    assign pix_on   = !(r_ax < 0 || r_ax >= act_w_s || r_ay < 0 || r_ay >= act_h_s);
    assign pix_addr = AW'(int'(r_ay[YC_W-1:0]) * WORDS_PER_ROW + int'(r_ax[XC_W-1:5]));

    // Current fill word and its edge mask.
    assign fill_addr = r_base + AW'(r_word);
    assign cur_mask  = ((r_word == r_w0) ? r_lmask : WORD_ONES)
                     & ((r_word == r_w1) ? r_rmask : WORD_ONES);

    // Memory port selection: clearing pass, or write-back of the word read last cycle.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_addr;
        ram_wr_data = '0;
        if (r_state == S_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr;
        end else if (r_wr_vld) begin
            ram_wr_en         = 1'b1;
            ram_wr_data.red   = r_cr ? (ram_rd_data.red | r_wr_mask)
                                     : (ram_rd_data.red & ~r_wr_mask);
            ram_wr_data.green = r_cg ? (ram_rd_data.green | r_wr_mask)
                                     : (ram_rd_data.green & ~r_wr_mask);
            ram_wr_data.blue  = r_cb ? (ram_rd_data.blue | r_wr_mask)
                                     : (ram_rd_data.blue & ~r_wr_mask);
        end
        ram_rd_en   = (r_state == S_FILL) || (r_state == S_SETUP && r_op == OP_READ);
        ram_rd_addr = (r_state == S_FILL) ? fill_addr : pix_addr;
    end

    brf_ram #(
        .WIDTH ($bits(t_planes)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_op == OP_READ) begin
                    n_state = pix_on ? S_READ : S_IDLE;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_word == r_w1 && r_row == r_y1) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_IDLE;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign bit_sel = 5'd31 - r_ax[4:0];
    assign cfg_wr  = psel && penable && pwrite;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_wr_vld <= 1'b0;
            r_done   <= 1'b0;
            r_sw     <= XC_W'(320);
            r_sh     <= YC_W'(240);
        end else begin
            r_state  <= n_state;
            r_wr_vld <= (r_state == S_FILL);
            r_done   <= (r_state == S_SETUP && r_op == OP_READ && !pix_on)
                        || r_state == S_FLUSH || r_state == S_READ;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (cfg_wr) begin
                case (paddr[2])
                    REG_SCREEN_WIDTH:  r_sw <= pwdata[XC_W-1:0];
                    REG_SCREEN_HEIGHT: r_sh <= pwdata[YC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Item and walk registers.
    always_ff @(posedge i_clk) begin
        // Capture an accepted item.
        if (r_state == S_IDLE && start) begin
            r_op <= i_op;
            r_ax <= i_corner_a_x;
            r_ay <= i_corner_a_y;
            r_bx <= i_corner_b_x;
            r_by <= i_corner_b_y;
            r_cr <= (i_colour & RED_MASK) != '0;
            r_cg <= (i_colour & GREEN_MASK) != '0;
            r_cb <= (i_colour & BLUE_MASK) != '0;
        end
        // Load the walk over the clamped rectangle.
        if (r_state == S_SETUP) begin
            r_row   <= y0c;
            r_y1    <= y1c;
            r_base  <= AW'(int'(y0c) * WORDS_PER_ROW);
            r_w0    <= WW'(x0c[XC_W-1:5]);
            r_word  <= WW'(x0c[XC_W-1:5]);
            r_w1    <= WW'(x1c[XC_W-1:5]);
            r_lmask <= WORD_ONES >> x0c[4:0];
            r_rmask <= WORD_ONES << (5'd31 - x1c[4:0]);
        end
        // Step one word per cycle, row by row.
        if (r_state == S_FILL) begin
            r_wr_addr <= fill_addr;
            r_wr_mask <= cur_mask;
            if (r_word == r_w1) begin
                r_word <= r_w0;
                r_row  <= r_row + 1'b1;
                r_base <= r_base + AW'(WORDS_PER_ROW);
            end else begin
                r_word <= r_word + 1'b1;
            end
        end
        // Result fields.
        if (r_state == S_SETUP || r_state == S_FLUSH) begin
            r_in_range <= (r_state == S_FLUSH) ? 1'b1 : 1'b0;
            r_red      <= 1'b0;
            r_green    <= 1'b0;
            r_blue     <= 1'b0;
        end else if (r_state == S_READ) begin
            r_in_range <= 1'b1;
            r_red      <= ram_rd_data.red[bit_sel];
            r_green    <= ram_rd_data.green[bit_sel];
            r_blue     <= ram_rd_data.blue[bit_sel];
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[2])
            REG_SCREEN_WIDTH:  prdata = {{(APB_DW-XC_W){1'b0}}, r_sw};
            REG_SCREEN_HEIGHT: prdata = {{(APB_DW-YC_W){1'b0}}, r_sh};
            default:           prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_in_range  = r_in_range;
    assign o_red_bit   = r_red;
    assign o_green_bit = r_green;
    assign o_blue_bit  = r_blue;

endmodule

// File: rtl/brf_ram.sv
`timescale 1ns / 1ps

module brf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2400
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: rtl/brf_checker.sv
`timescale 1ns / 1ps
`include "bitplane_rectangle_fill_macros.svh"

module brf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_in_range,
    input logic o_red_bit,
    input logic o_green_bit,
    input logic o_blue_bit
);

    // A result is only shown once the engine has gone idle.
    `BRF_ASSERT_IMPL(a_done_when_idle, i_clk, i_rst_n, o_done, !busy)

    // An accepted item always occupies the engine in the next cycle.
    `BRF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // Each item gives one result, never two strobes in a row.
    `BRF_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_done, !o_done)

    // An off-screen read reports no plane bits.
    `BRF_ASSERT_IMPL(a_off_screen_zero, i_clk, i_rst_n, o_done && !o_in_range,
        !o_red_bit && !o_green_bit && !o_blue_bit)

endmodule

bind bitplane_rectangle_fill brf_checker u_brf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_in_range  (o_in_range),
    .o_red_bit   (o_red_bit),
    .o_green_bit (o_green_bit),
    .o_blue_bit  (o_blue_bit)
);
